>>> design/hlpt_pkg.sv
package hlpt_pkg;

  // table geometry, slot count is a power of two
  localparam int SLOT_W      = 8;
  localparam int TABLE_SLOTS = 1 << SLOT_W;

  localparam int MODE_W   = 3;
  localparam int KEY_W    = 64;
  localparam int SITE_W   = 64;
  localparam int LINE_W   = 31;
  localparam int SEL_W    = 8;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 8;

  localparam int HASH_SHIFT_A = 8;
  localparam int HASH_SHIFT_B = 16;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_BEGIN_WAIT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_END_WAIT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRY_RESULT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_SLOT  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUSY     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_MISSING  = 3'd4;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  lock_id;
    logic [SITE_W-1:0] site_tag;
    logic [LINE_W-1:0] line_number;
    logic              success;
    logic [SEL_W-1:0]  slot_select;
  } hlpt_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot_index;
    logic                entry_used;
    logic [KEY_W-1:0]    entry_lock_id;
    logic [SITE_W-1:0]   entry_site;
    logic [LINE_W-1:0]   entry_line;
    logic                is_waiting;
    logic [KEY_W-1:0]    wait_lock_id;
    logic [SITE_W-1:0]   wait_site;
    logic [LINE_W-1:0]   wait_line;
  } hlpt_res_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic probe;
    logic clear;
    logic finish;
  } hlpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_probe;
    logic probe_done;
    logic clear_last;
    logic out_free;
  } hlpt_sts_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_PROBE,
    ST_DONE
  } hlpt_state_e;

  function automatic slot_t home_slot(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] h;
    h = key ^ (key >> HASH_SHIFT_A) ^ (key >> HASH_SHIFT_B);
    return h[SLOT_W-1:0];
  endfunction

  function automatic slot_t sel_to_slot(logic [SEL_W-1:0] sel);
    logic [SEL_W+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, sel};
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_to_index(slot_t s);
    logic [SLOT_W+IDX_W-1:0] w;
    w = {{IDX_W{1'b0}}, s};
    return w[IDX_W-1:0];
  endfunction

endpackage

>>> design/hlpt_if.sv
interface hlpt_in_if import hlpt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  lock_id;
  logic [SITE_W-1:0] site_tag;
  logic [LINE_W-1:0] line_number;
  logic              success;
  logic [SEL_W-1:0]  slot_select;

  modport source (
    output valid, mode, lock_id, site_tag, line_number, success, slot_select,
    input  ready
  );
  modport sink (
    input  valid, mode, lock_id, site_tag, line_number, success, slot_select,
    output ready
  );
endinterface

interface hlpt_out_if import hlpt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    slot_index;
  logic                entry_used;
  logic [KEY_W-1:0]    entry_lock_id;
  logic [SITE_W-1:0]   entry_site;
  logic [LINE_W-1:0]   entry_line;
  logic                is_waiting;
  logic [KEY_W-1:0]    wait_lock_id;
  logic [SITE_W-1:0]   wait_site;
  logic [LINE_W-1:0]   wait_line;

  modport source (
    output valid, status, slot_index, entry_used, entry_lock_id, entry_site, entry_line,
           is_waiting, wait_lock_id, wait_site, wait_line,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, entry_used, entry_lock_id, entry_site, entry_line,
           is_waiting, wait_lock_id, wait_site, wait_line,
    output ready
  );
endinterface

>>> design/hlpt_datapath.sv
module hlpt_datapath import hlpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hlpt_cmd_t  cmd_i,
  input  hlpt_item_t item_i,
  input  logic       out_ready_i,
  output hlpt_sts_t  sts_o,
  output logic       out_valid_o,
  output hlpt_res_t  res_o
);

  // slot storage
  logic [KEY_W-1:0]  key_mem  [TABLE_SLOTS];
  logic [SITE_W-1:0] site_mem [TABLE_SLOTS];
  logic [LINE_W-1:0] line_mem [TABLE_SLOTS];

  hlpt_item_t          item_q;
  logic [KEY_W-1:0]    wait_key_q;
  logic [SITE_W-1:0]   wait_site_q;
  logic [LINE_W-1:0]   wait_line_q;
  slot_t               addr_q;
  slot_t               rd_addr_q;
  logic                rd_vld_q;
  slot_t               chk_cnt_q;
  logic                is_insert_q;
  logic [STATUS_W-1:0] res_status_q;
  slot_t               res_slot_q;
  logic [KEY_W-1:0]    rd_key_q;
  logic [SITE_W-1:0]   rd_site_q;
  logic [LINE_W-1:0]   rd_line_q;
  logic                out_valid_q;
  hlpt_res_t           res_q;

  logic [STATUS_W-1:0] exec_status;
  logic                exec_probe;
  logic                exec_insert;
  logic                wait_load;
  logic                wait_clear;
  slot_t               sel_slot;
  logic                match;
  logic                hit;
  logic                miss;
  logic                rd_en;
  slot_t               rd_addr;
  logic                wr_key_en;
  logic                wr_data_en;
  slot_t               wr_addr;
  logic [KEY_W-1:0]    wr_key;
  logic [SITE_W-1:0]   wr_site;
  logic [LINE_W-1:0]   wr_line;
  hlpt_res_t           res_d;

  assign sel_slot = sel_to_slot(item_q.slot_select);

  // decode of the latched word against the wait slot
  always_comb begin
    exec_status = STATUS_OK;
    exec_probe  = 1'b0;
    exec_insert = 1'b0;
    wait_load   = 1'b0;
    wait_clear  = 1'b0;
    unique case (item_q.mode)
      MODE_BEGIN_WAIT: begin
        if (wait_key_q != '0) begin
          exec_status = STATUS_BUSY;
        end else begin
          wait_load = 1'b1;
        end
      end
      MODE_END_WAIT: begin
        if (wait_key_q != item_q.lock_id) begin
          exec_status = STATUS_MISMATCH;
        end else begin
          wait_clear  = 1'b1;
          exec_probe  = item_q.success;
          exec_insert = 1'b1;
        end
      end
      MODE_TRY_RESULT: begin
        exec_probe  = item_q.success;
        exec_insert = 1'b1;
      end
      MODE_RELEASE: begin
        exec_probe = item_q.success;
      end
      default: ;
    endcase
  end

  // probe compare on the registered read
  assign match = (rd_key_q == (is_insert_q ? '0 : item_q.lock_id));
  assign hit   = rd_vld_q && match;
  assign miss  = rd_vld_q && !match && (chk_cnt_q == SLOT_W'(TABLE_SLOTS - 1));

  assign rd_en   = cmd_i.exec || cmd_i.probe;
  assign rd_addr = cmd_i.probe ? addr_q : sel_slot;

  assign wr_key_en  = cmd_i.clear || (cmd_i.probe && hit);
  assign wr_data_en = cmd_i.clear || (cmd_i.probe && hit && is_insert_q);
  assign wr_addr    = cmd_i.clear ? addr_q : rd_addr_q;
  assign wr_key     = (cmd_i.clear || !is_insert_q) ? '0 : item_q.lock_id;
  assign wr_site    = cmd_i.clear ? '0 : item_q.site_tag;
  assign wr_line    = cmd_i.clear ? '0 : item_q.line_number;

  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_data_en) begin
      site_mem[wr_addr] <= wr_site;
      line_mem[wr_addr] <= wr_line;
    end
    if (rd_en) begin
      rd_key_q  <= key_mem[rd_addr];
      rd_site_q <= site_mem[rd_addr];
      rd_line_q <= line_mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      chk_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      wait_key_q  <= '0;
      wait_site_q <= '0;
      wait_line_q <= '0;
    end else begin
      if (cmd_i.clear || cmd_i.probe) begin
        addr_q <= addr_q + 1'b1;
      end else if (cmd_i.exec) begin
        addr_q <= home_slot(item_q.lock_id);
      end
      if (cmd_i.exec) begin
        rd_vld_q  <= 1'b0;
        chk_cnt_q <= '0;
      end else if (cmd_i.probe) begin
        rd_vld_q <= 1'b1;
        if (rd_vld_q) begin
          chk_cnt_q <= chk_cnt_q + 1'b1;
        end
      end
      if (cmd_i.exec && wait_load) begin
        wait_key_q  <= item_q.lock_id;
        wait_site_q <= item_q.site_tag;
        wait_line_q <= item_q.line_number;
      end else if (cmd_i.exec && wait_clear) begin
        wait_key_q <= '0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    res_d               = '0;
    res_d.status        = res_status_q;
    res_d.slot_index    = slot_to_index(res_slot_q);
    if (item_q.mode == MODE_READ_SLOT) begin
      res_d.entry_used    = (rd_key_q != '0);
      res_d.entry_lock_id = rd_key_q;
      res_d.entry_site    = rd_site_q;
      res_d.entry_line    = rd_line_q;
    end
    res_d.is_waiting    = (wait_key_q != '0);
    res_d.wait_lock_id  = wait_key_q;
    res_d.wait_site     = wait_site_q;
    res_d.wait_line     = wait_line_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      is_insert_q  <= exec_insert;
      res_status_q <= exec_status;
      res_slot_q   <= (item_q.mode == MODE_READ_SLOT) ? sel_slot : '0;
    end else if (cmd_i.probe && hit) begin
      res_status_q <= STATUS_OK;
      res_slot_q   <= rd_addr_q;
    end else if (cmd_i.probe && miss) begin
      res_status_q <= is_insert_q ? STATUS_FULL : STATUS_MISSING;
      res_slot_q   <= '0;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign sts_o.need_probe = exec_probe;
  assign sts_o.probe_done = hit || miss;
  assign sts_o.clear_last = (addr_q == SLOT_W'(TABLE_SLOTS - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> design/hlpt_ctrl.sv
module hlpt_ctrl import hlpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  hlpt_sts_t sts_i,
  output logic      in_ready_o,
  output hlpt_cmd_t cmd_o
);

  hlpt_state_e state_q;
  hlpt_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_probe ? ST_PROBE : ST_DONE;
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.probe_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/held_lock_probe_table.sv
// held-lock probe table: tracks the locks one agent holds in an open-addressed set of
// TABLE_SLOTS slots (home slot is key ^ key>>8 ^ key>>16, linear probing with wrap, key
// zero marks an empty slot) plus a single wait slot for the lock it is waiting on. each
// input word is one operation and returns exactly one result word. after reset the block
// sweeps all TABLE_SLOTS slots of the slot memory to zero and holds in_i.ready low
// meanwhile. words are handled one at a time: a word that touches only the wait slot
// or reads a slot goes from accept through decode to the result, an insert or remove
// also runs the probe loop, which reads one key per cycle from the slot memory and
// visits at most TABLE_SLOTS slots. the result sits in an output register, so the next
// word is accepted while the previous result waits
module held_lock_probe_table import hlpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  hlpt_in_if.sink           in_i,
  hlpt_out_if.source        out_o
);

  hlpt_cmd_t  cmd;
  hlpt_sts_t  sts;
  hlpt_item_t item;
  hlpt_res_t  res;
  logic       out_valid;

  // pack the incoming word
  assign item.mode        = in_i.mode;
  assign item.lock_id     = in_i.lock_id;
  assign item.site_tag    = in_i.site_tag;
  assign item.line_number = in_i.line_number;
  assign item.success     = in_i.success;
  assign item.slot_select = in_i.slot_select;

  // sequencer: clear sweep, accept, decode, probe loop, result hand-off
  hlpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  // slot memory, wait slot, probe counters and the result register
  hlpt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item),
    .out_ready_i (out_o.ready),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  // unpack the result word
  assign out_o.valid         = out_valid;
  assign out_o.status        = res.status;
  assign out_o.slot_index    = res.slot_index;
  assign out_o.entry_used    = res.entry_used;
  assign out_o.entry_lock_id = res.entry_lock_id;
  assign out_o.entry_site    = res.entry_site;
  assign out_o.entry_line    = res.entry_line;
  assign out_o.is_waiting    = res.is_waiting;
  assign out_o.wait_lock_id  = res.wait_lock_id;
  assign out_o.wait_site     = res.wait_site;
  assign out_o.wait_line     = res.wait_line;

endmodule
